// ===== hw/rtl/sd_card_spi_host_engine_macros.svh =====
// assertion macros for the sd card spi host engine
`ifndef SD_CARD_SPI_HOST_ENGINE_MACROS_SVH
`define SD_CARD_SPI_HOST_ENGINE_MACROS_SVH
// clocked implication check with synchronous reset gating
`define SDSPI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");
// next-cycle implication check
`define SDSPI_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");
`endif

// ===== hw/rtl/sdspi_pkg.sv =====
// shared types and constants of the sd card spi host engine
package sdspi_pkg;

  localparam int unsigned BlockBytes = 512;
  localparam int unsigned IdlePreambleBytes = 10;

  typedef enum logic [1:0] {
    CMD_INIT  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_BYTE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_IDLE  = 2'd1,
    ST_RD_FAIL  = 2'd2,
    ST_WR_FAIL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_RESP_ATTEMPTS = 2'd0,
    CFG_BUSY_LIMIT    = 2'd1,
    CFG_SDV2_RETRIES  = 2'd2,
    CFG_LEGACY_RETRIES= 2'd3
  } cfg_idx_t;

  typedef enum logic [4:0] {
    P_IDLE, P_PRE, P_DESEL, P_SEL, P_FRAME, P_POLL, P_REL8, P_OCR8, P_OCR58,
    P_RD_REL, P_RD_TOKEN, P_RD_DATA, P_RD_CRC,
    P_WR_REL, P_WR_TOKEN, P_WR_DATA, P_WR_CRC, P_WR_RESP, P_WR_BUSY
  } phase_t;

  typedef enum logic [3:0] {
    K_NONE, K_CMD0, K_CMD8, K_HCS, K_CMD58, K_PROBE, K_LEGACY, K_CMD16,
    K_CMD17, K_CMD24
  } resume_t;

  localparam logic [7:0] OP_GO_IDLE  = 8'h40;
  localparam logic [7:0] OP_MMC_INIT = 8'h41;
  localparam logic [7:0] OP_IF_COND  = 8'h48;
  localparam logic [7:0] OP_BLOCKLEN = 8'h50;
  localparam logic [7:0] OP_READ1    = 8'h51;
  localparam logic [7:0] OP_WRITE1   = 8'h58;
  localparam logic [7:0] OP_APP      = 8'h77;
  localparam logic [7:0] OP_READ_OCR = 8'h7A;
  localparam logic [7:0] OP_APP_INIT = 8'hE9;

  localparam logic [2:0] TYPE_UNKNOWN = 3'd0;
  localparam logic [2:0] TYPE_MMC     = 3'd1;
  localparam logic [2:0] TYPE_SDV1    = 3'd2;
  localparam logic [2:0] TYPE_SDV2    = 3'd3;
  localparam logic [2:0] TYPE_SDV2_BA = 3'd4;

  // sequencer state carried from one exchange to the next
  typedef struct packed {
    phase_t      phase;
    resume_t     resume;
    logic [15:0] byte_cnt;
    logic [7:0]  attempt_cnt;
    logic [14:0] retry_cnt;
    logic [7:0]  cmd_idx;
    logic [31:0] arg;
    logic [31:0] ocr;
    logic [2:0]  ctype;
  } seq_t;

  // one result item
  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       select_card;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       took_write_data;
    logic       done_res;
    logic [1:0] status;
    logic [2:0] card_type;
  } res_t;

  // configuration registers
  typedef struct packed {
    logic [7:0]  resp_attempts;
    logic [15:0] busy_limit;
    logic [14:0] sdv2_retries;
    logic [14:0] legacy_retries;
  } cfg_t;

endpackage

// ===== hw/rtl/sdspi_step.sv =====
// next-state and result logic for one spi byte exchange
module sdspi_step import sdspi_pkg::*; (
  input  seq_t       cur,
  input  cfg_t       cfg,
  input  logic [1:0] command,
  input  logic [31:0] block_address,
  input  logic [7:0] card_byte,
  input  logic [7:0] write_data,
  output seq_t       nxt,
  output res_t       res
);

  logic        app;
  logic [7:0]  wire_idx;
  logic [31:0] farg;
  logic [7:0]  fbyte;
  logic [15:0] fk;
  logic [31:0] ocr_sh;
  logic [15:0] bc_inc;
  logic [14:0] rc_dec;
  logic [7:0]  r;

  // frame byte for the next frame position
  always_comb begin
    app      = cur.cmd_idx[7];
    wire_idx = app ? OP_APP : cur.cmd_idx;
    farg     = app ? 32'd0 : cur.arg;
    fk       = cur.byte_cnt + 16'd1;
    case (fk)
      16'd1:   fbyte = farg[31:24];
      16'd2:   fbyte = farg[23:16];
      16'd3:   fbyte = farg[15:8];
      16'd4:   fbyte = farg[7:0];
      default: fbyte = (wire_idx == OP_GO_IDLE) ? 8'h95 :
                       (wire_idx == OP_IF_COND) ? 8'h87 : 8'h01;
    endcase
  end

  assign ocr_sh = {cur.ocr[23:0], card_byte};
  assign bc_inc = cur.byte_cnt + 16'd1;
  assign rc_dec = cur.retry_cnt - 15'd1;
  assign r      = card_byte;

  always_comb begin
    nxt = cur;
    res = '0;
    if (command == CMD_INIT) begin
      nxt.ctype = TYPE_UNKNOWN; nxt.byte_cnt = 16'd1; nxt.phase = P_PRE;
      res.send_valid = 1'b1; res.send_byte = 8'hFF;
    end else if (command == CMD_READ || command == CMD_WRITE) begin
      nxt.cmd_idx = (command == CMD_READ) ? OP_READ1 : OP_WRITE1;
      nxt.arg     = block_address;
      nxt.resume  = (command == CMD_READ) ? K_CMD17 : K_CMD24;
      nxt.phase   = P_DESEL;
      res.send_valid = 1'b1; res.send_byte = 8'hFF;
    end else begin
      case (cur.phase)
        P_PRE: begin
          res.send_valid = 1'b1; res.send_byte = 8'hFF;
          if (cur.byte_cnt < 16'(IdlePreambleBytes)) nxt.byte_cnt = bc_inc;
          else begin
            nxt.cmd_idx = OP_GO_IDLE; nxt.arg = '0; nxt.resume = K_CMD0;
            nxt.phase = P_DESEL;
          end
        end
        P_DESEL: begin
          nxt.phase = P_SEL; res.send_valid = 1'b1; res.send_byte = 8'hFF;
          res.select_card = 1'b1;
        end
        P_SEL: begin
          nxt.phase = P_FRAME; nxt.byte_cnt = '0;
          res.send_valid = 1'b1; res.send_byte = wire_idx; res.select_card = 1'b1;
        end
        P_FRAME: begin
          res.send_valid = 1'b1; res.select_card = 1'b1;
          if (cur.byte_cnt < 16'd5) begin
            nxt.byte_cnt = bc_inc; res.send_byte = fbyte;
          end else begin
            nxt.phase = P_POLL; nxt.attempt_cnt = cfg.resp_attempts;
            res.send_byte = 8'hFF;
          end
        end
        P_POLL: begin
          if (r[7] && cur.attempt_cnt > 8'd1) begin
            nxt.attempt_cnt = cur.attempt_cnt - 8'd1;
            res.send_valid = 1'b1; res.send_byte = 8'hFF; res.select_card = 1'b1;
          end else if (app && r <= 8'd1) begin
            // cmd55 accepted, now the real acmd
            nxt.cmd_idx = {1'b0, cur.cmd_idx[6:0]}; nxt.phase = P_DESEL;
            res.send_valid = 1'b1; res.send_byte = 8'hFF;
          end else begin
            // command finished, dispatch on continuation
            case (cur.resume)
              K_CMD0: begin
                if (r == 8'd1) begin
                  nxt.phase = P_REL8; res.send_valid = 1'b1; res.send_byte = 8'hFF;
                  res.select_card = 1'b1;
                end else begin
                  nxt.phase = P_IDLE; res.done_res = 1'b1; res.status = ST_NO_IDLE;
                end
              end
              K_CMD8: begin
                res.send_valid = 1'b1; res.send_byte = 8'hFF;
                if (r == 8'd1) begin
                  nxt.ocr = '0; nxt.byte_cnt = '0; nxt.phase = P_OCR8;
                  res.select_card = 1'b1;
                end else begin
                  nxt.cmd_idx = OP_APP_INIT; nxt.arg = '0; nxt.resume = K_PROBE;
                  nxt.phase = P_DESEL;
                end
              end
              K_HCS: begin
                if (r == 8'd0) begin
                  nxt.cmd_idx = OP_READ_OCR; nxt.arg = '0; nxt.resume = K_CMD58;
                  nxt.phase = P_DESEL; res.send_valid = 1'b1; res.send_byte = 8'hFF;
                end else begin
                  nxt.retry_cnt = rc_dec;
                  if (rc_dec == '0) begin
                    nxt.phase = P_IDLE; res.done_res = 1'b1;
                  end else begin
                    nxt.cmd_idx = OP_APP_INIT; nxt.arg = 32'h4000_0000;
                    nxt.phase = P_DESEL; res.send_valid = 1'b1; res.send_byte = 8'hFF;
                  end
                end
              end
              K_CMD58: begin
                if (r == 8'd0) begin
                  nxt.ocr = '0; nxt.byte_cnt = '0; nxt.phase = P_OCR58;
                  res.send_valid = 1'b1; res.send_byte = 8'hFF; res.select_card = 1'b1;
                end else begin
                  nxt.phase = P_IDLE; res.done_res = 1'b1;
                end
              end
              K_PROBE, K_LEGACY: begin
                if (cur.resume == K_LEGACY && r == 8'd0) begin
                  nxt.cmd_idx = OP_BLOCKLEN; nxt.arg = 32'(BlockBytes);
                  nxt.resume = K_CMD16; nxt.phase = P_DESEL;
                  res.send_valid = 1'b1; res.send_byte = 8'hFF;
                end else begin
                  if (cur.resume == K_PROBE) begin
                    nxt.ctype = (r <= 8'd1) ? TYPE_SDV1 : TYPE_MMC;
                    nxt.retry_cnt = cfg.legacy_retries;
                  end else begin
                    nxt.retry_cnt = rc_dec;
                  end
                  if (nxt.retry_cnt == '0) begin
                    nxt.ctype = TYPE_UNKNOWN; nxt.phase = P_IDLE; res.done_res = 1'b1;
                  end else begin
                    nxt.cmd_idx = (nxt.ctype == TYPE_SDV1) ? OP_APP_INIT : OP_MMC_INIT;
                    nxt.arg = '0; nxt.resume = K_LEGACY; nxt.phase = P_DESEL;
                    res.send_valid = 1'b1; res.send_byte = 8'hFF;
                  end
                end
              end
              K_CMD16: begin
                if (r != 8'd0) nxt.ctype = TYPE_UNKNOWN;
                nxt.phase = P_IDLE; res.done_res = 1'b1;
              end
              K_CMD17: begin
                if (r == 8'd0) begin
                  nxt.phase = P_RD_REL; res.send_valid = 1'b1; res.send_byte = 8'hFF;
                  res.select_card = 1'b1;
                end else begin
                  nxt.phase = P_IDLE; res.done_res = 1'b1; res.status = ST_RD_FAIL;
                end
              end
              K_CMD24: begin
                if (r == 8'd0) begin
                  nxt.phase = P_WR_REL; res.send_valid = 1'b1; res.send_byte = 8'hFF;
                  res.select_card = 1'b1;
                end else begin
                  nxt.phase = P_IDLE; res.done_res = 1'b1; res.status = ST_WR_FAIL;
                end
              end
              default: begin
                nxt.phase = P_IDLE; res.done_res = 1'b1;
              end
            endcase
          end
        end
        P_REL8: begin
          nxt.cmd_idx = OP_IF_COND; nxt.arg = 32'h0000_01AA; nxt.resume = K_CMD8;
          nxt.phase = P_DESEL; res.send_valid = 1'b1; res.send_byte = 8'hFF;
        end
        P_OCR8, P_OCR58: begin
          nxt.ocr = ocr_sh; nxt.byte_cnt = bc_inc;
          if (bc_inc < 16'd4) begin
            res.send_valid = 1'b1; res.send_byte = 8'hFF; res.select_card = 1'b1;
          end else if (cur.phase == P_OCR58) begin
            nxt.ctype = ocr_sh[30] ? TYPE_SDV2_BA : TYPE_SDV2;
            nxt.phase = P_IDLE; res.done_res = 1'b1;
          end else if (ocr_sh[15:0] == 16'h01AA && cfg.sdv2_retries != '0) begin
            nxt.retry_cnt = cfg.sdv2_retries;
            nxt.cmd_idx = OP_APP_INIT; nxt.arg = 32'h4000_0000; nxt.resume = K_HCS;
            nxt.phase = P_DESEL; res.send_valid = 1'b1; res.send_byte = 8'hFF;
          end else begin
            if (ocr_sh[15:0] == 16'h01AA) nxt.retry_cnt = cfg.sdv2_retries;
            nxt.phase = P_IDLE; res.done_res = 1'b1;
          end
        end
        P_RD_REL: begin
          nxt.byte_cnt = cfg.busy_limit; nxt.phase = P_RD_TOKEN;
          res.send_valid = 1'b1; res.send_byte = 8'hFF; res.select_card = 1'b1;
        end
        P_RD_TOKEN: begin
          if (r == 8'hFE) begin
            nxt.byte_cnt = '0; nxt.phase = P_RD_DATA;
            res.send_valid = 1'b1; res.send_byte = 8'hFF; res.select_card = 1'b1;
          end else if (cur.byte_cnt <= 16'd1) begin
            nxt.phase = P_IDLE; res.done_res = 1'b1; res.status = ST_RD_FAIL;
          end else begin
            nxt.byte_cnt = cur.byte_cnt - 16'd1;
            res.send_valid = 1'b1; res.send_byte = 8'hFF; res.select_card = 1'b1;
          end
        end
        P_RD_DATA: begin
          res.read_valid = 1'b1; res.read_byte = r;
          nxt.byte_cnt = bc_inc;
          if (bc_inc >= 16'(BlockBytes)) begin
            nxt.byte_cnt = 16'd1; nxt.phase = P_RD_CRC;
          end
          res.send_valid = 1'b1; res.send_byte = 8'hFF; res.select_card = 1'b1;
        end
        P_RD_CRC: begin
          if (cur.byte_cnt < 16'd2) begin
            nxt.byte_cnt = bc_inc;
            res.send_valid = 1'b1; res.send_byte = 8'hFF; res.select_card = 1'b1;
          end else begin
            nxt.phase = P_IDLE; res.done_res = 1'b1;
          end
        end
        P_WR_REL: begin
          nxt.phase = P_WR_TOKEN;
          res.send_valid = 1'b1; res.send_byte = 8'hFE; res.select_card = 1'b1;
        end
        P_WR_TOKEN: begin
          res.took_write_data = 1'b1; nxt.byte_cnt = 16'd1; nxt.phase = P_WR_DATA;
          res.send_valid = 1'b1; res.send_byte = write_data; res.select_card = 1'b1;
        end
        P_WR_DATA: begin
          res.send_valid = 1'b1; res.select_card = 1'b1;
          if (cur.byte_cnt < 16'(BlockBytes)) begin
            res.took_write_data = 1'b1; res.send_byte = write_data;
            nxt.byte_cnt = bc_inc;
          end else begin
            nxt.byte_cnt = 16'd1; nxt.phase = P_WR_CRC; res.send_byte = 8'hFF;
          end
        end
        P_WR_CRC: begin
          if (cur.byte_cnt < 16'd2) nxt.byte_cnt = bc_inc;
          else nxt.phase = P_WR_RESP;
          res.send_valid = 1'b1; res.send_byte = 8'hFF; res.select_card = 1'b1;
        end
        P_WR_RESP: begin
          if (r[4:0] != 5'h05) begin
            nxt.phase = P_IDLE; res.done_res = 1'b1; res.status = ST_WR_FAIL;
          end else begin
            nxt.byte_cnt = cfg.busy_limit; nxt.phase = P_WR_BUSY;
            res.send_valid = 1'b1; res.send_byte = 8'hFF; res.select_card = 1'b1;
          end
        end
        P_WR_BUSY: begin
          if (r == 8'hFF) begin
            nxt.phase = P_IDLE; res.done_res = 1'b1;
          end else if (cur.byte_cnt <= 16'd1) begin
            nxt.phase = P_IDLE; res.done_res = 1'b1; res.status = ST_WR_FAIL;
          end else begin
            nxt.byte_cnt = cur.byte_cnt - 16'd1;
            res.send_valid = 1'b1; res.send_byte = 8'hFF; res.select_card = 1'b1;
          end
        end
        default: nxt.phase = P_IDLE;
      endcase
    end
    res.card_type = nxt.ctype;
  end

endmodule

// ===== hw/rtl/sd_card_spi_host_engine.sv =====
// top level of the sd card spi host engine
// Takes one transaction per spi byte exchange: a start request or the byte
// the card returned, and gives one result transaction per input in the
// following cycle, through a single output register; a new input is taken
// every cycle while the output register is empty or being drained. The
// step logic is a single combinational pass over the sequencer state.
module sd_card_spi_host_engine import sdspi_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_command,
  input  logic [31:0] in_block_address,
  input  logic [7:0]  in_card_byte,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_send_valid,
  output logic [7:0]  out_send_byte,
  output logic        out_select_card,
  output logic        out_read_valid,
  output logic [7:0]  out_read_byte,
  output logic        out_took_write_data,
  output logic        out_done_res,
  output logic [1:0]  out_status,
  output logic [2:0]  out_card_type,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  seq_t seq_r, seq_nxt;
  cfg_t cfg_r;
  res_t res_r, res_nxt;
  logic out_valid_r;
  logic acc;

  assign in_ready  = !out_valid_r || out_ready;
  assign acc       = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  sdspi_step u_step (
    .cur(seq_r), .cfg(cfg_r), .command(in_command),
    .block_address(in_block_address), .card_byte(in_card_byte),
    .write_data(in_write_data), .nxt(seq_nxt), .res(res_nxt)
  );

  // sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r <= '{phase: P_IDLE, resume: K_NONE, default: '0};
    end else if (acc) begin
      seq_r <= seq_nxt;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{resp_attempts: 8'd10, busy_limit: 16'hFFFF,
                 sdv2_retries: 15'd12000, legacy_retries: 15'd25000};
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_RESP_ATTEMPTS:  cfg_r.resp_attempts  <= cfg_data[7:0];
        CFG_BUSY_LIMIT:     cfg_r.busy_limit     <= cfg_data;
        CFG_SDV2_RETRIES:   cfg_r.sdv2_retries   <= cfg_data[14:0];
        default:            cfg_r.legacy_retries <= cfg_data[14:0];
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_ready) begin
      out_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) res_r <= res_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_send_valid      = res_r.send_valid;
  assign out_send_byte       = res_r.send_byte;
  assign out_select_card     = res_r.select_card;
  assign out_read_valid      = res_r.read_valid;
  assign out_read_byte       = res_r.read_byte;
  assign out_took_write_data = res_r.took_write_data;
  assign out_done_res        = res_r.done_res;
  assign out_status          = res_r.status;
  assign out_card_type       = res_r.card_type;

endmodule

// ===== hw/rtl/sdspi_checker.sv =====
// port-level checks for the sd card spi host engine, bound to the top level
`include "sd_card_spi_host_engine_macros.svh"
module sdspi_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_send_valid,
  input logic       out_select_card,
  input logic       out_read_valid,
  input logic       out_done_res,
  input logic [1:0] out_status
);
  `SDSPI_ASSERT_NXT(a_in_to_out, in_valid && in_ready, out_valid)
  `SDSPI_ASSERT_IMP(a_stall_blocks, out_valid && !out_ready, !in_ready)
  `SDSPI_ASSERT_IMP(a_done_no_send, out_valid && out_done_res, !out_send_valid)
  `SDSPI_ASSERT_IMP(a_read_selected, out_valid && out_read_valid,
                    out_send_valid && out_select_card)
  `SDSPI_ASSERT_IMP(a_status_quiet, out_valid && !out_done_res, out_status == 2'd0)
endmodule

bind sd_card_spi_host_engine sdspi_checker u_sdspi_checker (.*);

// ===== dv/testbench.sv =====
// self-checking testbench for the sd card spi host engine
`timescale 1ns / 1ps

module testbench;
  import sdspi_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_command;
  logic [31:0] in_block_address;
  logic [7:0]  in_card_byte;
  logic [7:0]  in_write_data;
  logic        out_valid;
  logic        out_ready;
  logic        out_send_valid;
  logic [7:0]  out_send_byte;
  logic        out_select_card;
  logic        out_read_valid;
  logic [7:0]  out_read_byte;
  logic        out_took_write_data;
  logic        out_done_res;
  logic [1:0]  out_status;
  logic [2:0]  out_card_type;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  sd_card_spi_host_engine DUT (.*);

  // clock
  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // sequencer model state and its copy of the registers
  phase_t      seq_phase;
  resume_t     seq_resume;
  logic [15:0] seq_bytes;
  logic [7:0]  seq_attempts;
  logic [14:0] seq_retries;
  logic [7:0]  seq_cmd;
  logic [31:0] seq_arg;
  logic [31:0] seq_ocr;
  logic [2:0]  seq_ctype;
  logic [7:0]  reg_attempts;
  logic [15:0] reg_busy_limit;
  logic [14:0] reg_sdv2_retries;
  logic [14:0] reg_legacy_retries;
  res_t        step_out;

  res_t        pending_results[$];
  int          items_sent;
  int          tx_idle_pct;
  int          rx_idle_pct;
  bit          hold_off;
  bit          failed;

  task automatic put_byte(input logic [7:0] b, input logic sel);
    step_out.send_valid  = 1'b1;
    step_out.send_byte   = b;
    step_out.select_card = sel;
  endtask

  task automatic end_request(input status_t st);
    seq_phase = P_IDLE;
    step_out.done_res = 1'b1;
    step_out.status = st;
  endtask

  task automatic open_command(input logic [7:0] idx, input logic [31:0] arg,
                              input resume_t cont);
    seq_cmd = idx;
    seq_arg = arg;
    seq_resume = cont;
    seq_phase = P_DESEL;
    put_byte(8'hFF, 1'b0);
  endtask

  // byte k of the command frame, an app command goes out as cmd55 first
  function automatic logic [7:0] frame_at(input logic [15:0] k);
    logic [7:0]  wire_idx;
    logic [31:0] a;
    wire_idx = seq_cmd[7] ? OP_APP : seq_cmd;
    a = seq_cmd[7] ? 32'd0 : seq_arg;
    if (k == 0) return wire_idx;
    if (k <= 4) return 8'(a >> (8 * (4 - k)));
    if (wire_idx == OP_GO_IDLE) return 8'h95;
    if (wire_idx == OP_IF_COND) return 8'h87;
    return 8'h01;
  endfunction

  task automatic legacy_attempt();
    if (seq_retries == 0) begin
      seq_ctype = TYPE_UNKNOWN;
      end_request(ST_OK);
    end else begin
      open_command(seq_ctype == TYPE_SDV1 ? OP_APP_INIT : OP_MMC_INIT, 32'd0, K_LEGACY);
    end
  endtask

  task automatic r1_received(input logic [7:0] r);
    case (seq_resume)
      K_CMD0: begin
        if (r == 8'd1) begin
          seq_phase = P_REL8;
          put_byte(8'hFF, 1'b1);
        end else end_request(ST_NO_IDLE);
      end
      K_CMD8: begin
        if (r == 8'd1) begin
          seq_ocr = '0; seq_bytes = '0; seq_phase = P_OCR8; put_byte(8'hFF, 1'b1);
        end else open_command(OP_APP_INIT, 32'd0, K_PROBE);
      end
      K_HCS: begin
        if (r == 8'd0) open_command(OP_READ_OCR, 32'd0, K_CMD58);
        else begin
          seq_retries = seq_retries - 1'b1;
          if (seq_retries == 0) end_request(ST_OK);
          else open_command(OP_APP_INIT, 32'h4000_0000, K_HCS);
        end
      end
      K_CMD58: begin
        if (r == 8'd0) begin
          seq_ocr = '0; seq_bytes = '0; seq_phase = P_OCR58; put_byte(8'hFF, 1'b1);
        end else end_request(ST_OK);
      end
      K_PROBE: begin
        seq_ctype = (r <= 8'd1) ? TYPE_SDV1 : TYPE_MMC;
        seq_retries = reg_legacy_retries;
        legacy_attempt();
      end
      K_LEGACY: begin
        if (r == 8'd0) open_command(OP_BLOCKLEN, BlockBytes, K_CMD16);
        else begin
          seq_retries = seq_retries - 1'b1;
          legacy_attempt();
        end
      end
      K_CMD16: begin
        if (r != 8'd0) seq_ctype = TYPE_UNKNOWN;
        end_request(ST_OK);
      end
      K_CMD17: begin
        if (r == 8'd0) begin
          seq_phase = P_RD_REL; put_byte(8'hFF, 1'b1);
        end else end_request(ST_RD_FAIL);
      end
      K_CMD24: begin
        if (r == 8'd0) begin
          seq_phase = P_WR_REL; put_byte(8'hFF, 1'b1);
        end else end_request(ST_WR_FAIL);
      end
      default: end_request(ST_OK);
    endcase
  endtask

  // one exchange of the sequencer, result left in step_out
  task automatic predict_exchange(input req_t cmd, input logic [31:0] addr,
                                  input logic [7:0] rx, input logic [7:0] wd);
    step_out = '0;
    case (cmd)
      CMD_INIT: begin
        seq_ctype = TYPE_UNKNOWN; seq_bytes = 16'd1; seq_phase = P_PRE;
        put_byte(8'hFF, 1'b0);
      end
      CMD_READ:  open_command(OP_READ1, addr, K_CMD17);
      CMD_WRITE: open_command(OP_WRITE1, addr, K_CMD24);
      default: begin
        case (seq_phase)
          P_PRE: begin
            if (seq_bytes < IdlePreambleBytes) begin
              seq_bytes++; put_byte(8'hFF, 1'b0);
            end else open_command(OP_GO_IDLE, 32'd0, K_CMD0);
          end
          P_DESEL: begin
            seq_phase = P_SEL; put_byte(8'hFF, 1'b1);
          end
          P_SEL: begin
            seq_phase = P_FRAME; seq_bytes = '0; put_byte(frame_at(16'd0), 1'b1);
          end
          P_FRAME: begin
            if (seq_bytes < 5) begin
              seq_bytes++; put_byte(frame_at(seq_bytes), 1'b1);
            end else begin
              seq_phase = P_POLL; seq_attempts = reg_attempts; put_byte(8'hFF, 1'b1);
            end
          end
          P_POLL: begin
            if (rx[7] && seq_attempts > 1) begin
              seq_attempts--; put_byte(8'hFF, 1'b1);
            end else if (seq_cmd[7]) begin
              if (rx > 8'd1) r1_received(rx);
              else open_command({1'b0, seq_cmd[6:0]}, seq_arg, seq_resume);
            end else r1_received(rx);
          end
          P_REL8: open_command(OP_IF_COND, 32'h1AA, K_CMD8);
          P_OCR8, P_OCR58: begin
            seq_ocr = {seq_ocr[23:0], rx};
            seq_bytes++;
            if (seq_bytes < 4) put_byte(8'hFF, 1'b1);
            else if (seq_phase == P_OCR58) begin
              seq_ctype = seq_ocr[30] ? TYPE_SDV2_BA : TYPE_SDV2;
              end_request(ST_OK);
            end else if (seq_ocr[15:0] == 16'h01AA) begin
              seq_retries = reg_sdv2_retries;
              if (seq_retries == 0) end_request(ST_OK);
              else open_command(OP_APP_INIT, 32'h4000_0000, K_HCS);
            end else end_request(ST_OK);
          end
          P_RD_REL: begin
            seq_bytes = reg_busy_limit; seq_phase = P_RD_TOKEN; put_byte(8'hFF, 1'b1);
          end
          P_RD_TOKEN: begin
            if (rx == 8'hFE) begin
              seq_bytes = '0; seq_phase = P_RD_DATA; put_byte(8'hFF, 1'b1);
            end else if (seq_bytes <= 1) end_request(ST_RD_FAIL);
            else begin
              seq_bytes--; put_byte(8'hFF, 1'b1);
            end
          end
          P_RD_DATA: begin
            step_out.read_valid = 1'b1;
            step_out.read_byte = rx;
            seq_bytes++;
            if (seq_bytes >= BlockBytes) begin
              seq_bytes = 16'd1; seq_phase = P_RD_CRC;
            end
            put_byte(8'hFF, 1'b1);
          end
          P_RD_CRC: begin
            if (seq_bytes < 2) begin
              seq_bytes++; put_byte(8'hFF, 1'b1);
            end else end_request(ST_OK);
          end
          P_WR_REL: begin
            seq_phase = P_WR_TOKEN; put_byte(8'hFE, 1'b1);
          end
          P_WR_TOKEN: begin
            step_out.took_write_data = 1'b1; put_byte(wd, 1'b1);
            seq_bytes = 16'd1; seq_phase = P_WR_DATA;
          end
          P_WR_DATA: begin
            if (seq_bytes < BlockBytes) begin
              step_out.took_write_data = 1'b1; put_byte(wd, 1'b1); seq_bytes++;
            end else begin
              seq_bytes = 16'd1; seq_phase = P_WR_CRC; put_byte(8'hFF, 1'b1);
            end
          end
          P_WR_CRC: begin
            if (seq_bytes < 2) seq_bytes++;
            else seq_phase = P_WR_RESP;
            put_byte(8'hFF, 1'b1);
          end
          P_WR_RESP: begin
            if (rx[4:0] != 5'h05) end_request(ST_WR_FAIL);
            else begin
              seq_bytes = reg_busy_limit; seq_phase = P_WR_BUSY; put_byte(8'hFF, 1'b1);
            end
          end
          P_WR_BUSY: begin
            if (rx == 8'hFF) end_request(ST_OK);
            else if (seq_bytes <= 1) end_request(ST_WR_FAIL);
            else begin
              seq_bytes--; put_byte(8'hFF, 1'b1);
            end
          end
          default: seq_phase = P_IDLE;
        endcase
      end
    endcase
    step_out.card_type = seq_ctype;
  endtask

  // card behaviour: plausible answers for the current phase, some noise
  function automatic logic [7:0] card_reply();
    logic [7:0] any;
    any = 8'($urandom_range(255));
    if ($urandom_range(9) == 0) return any;
    case (seq_phase)
      P_POLL: begin
        if ($urandom_range(3) == 0) return 8'hFF;
        if (seq_cmd[7]) return ($urandom_range(7) == 0) ? 8'h05 : 8'h01;
        case (seq_resume)
          K_CMD0:   return ($urandom_range(7) == 0) ? 8'h05 : 8'h01;
          K_CMD8:   return ($urandom_range(2) == 0) ? 8'h05 : 8'h01;
          K_HCS:    return ($urandom_range(3) == 0) ? 8'h00 : 8'h01;
          K_PROBE:  return ($urandom_range(1) == 0) ? 8'h05 : 8'h01;
          K_LEGACY: return ($urandom_range(2) == 0) ? 8'h00 : 8'h01;
          default:  return ($urandom_range(7) == 0) ? 8'h04 : 8'h00;
        endcase
      end
      P_OCR8: begin
        case (seq_bytes)
          16'd2:   return 8'h01;
          16'd3:   return 8'hAA;
          default: return 8'h00;
        endcase
      end
      P_RD_TOKEN: return ($urandom_range(2) == 0) ? 8'hFF : 8'hFE;
      P_WR_RESP:  return ($urandom_range(3) == 0) ? any : {any[7:5], 5'h05};
      P_WR_BUSY:  return ($urandom_range(2) == 0) ? 8'hFF : 8'h00;
      default:    return any;
    endcase
  endfunction

  // send one transaction and record what it must produce
  task automatic send_item(input req_t cmd, input logic [31:0] addr,
                           input logic [7:0] rx, input logic [7:0] wd);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_block_address <= addr;
    in_card_byte <= rx;
    in_write_data <= wd;
    do @(posedge clk); while (!in_ready);
    predict_exchange(cmd, addr, rx, wd);
    pending_results.push_back(step_out);
    items_sent++;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  task automatic card_byte(input logic [7:0] rx);
    send_item(CMD_BYTE, $urandom(), rx, 8'($urandom_range(255)));
  endtask

  // start a request and answer as a card would for up to max_bytes exchanges
  task automatic run_request(input req_t cmd, input int max_bytes);
    int n;
    n = 0;
    send_item(cmd, $urandom(), 8'($urandom_range(255)), 8'($urandom_range(255)));
    while (seq_phase != P_IDLE && n < max_bytes) begin
      card_byte(card_reply());
      n++;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_RESP_ATTEMPTS: reg_attempts = value[7:0];
      CFG_BUSY_LIMIT:    reg_busy_limit = value;
      CFG_SDV2_RETRIES:  reg_sdv2_retries = value[14:0];
      default:           reg_legacy_retries = value[14:0];
    endcase
    @(posedge clk);
  endtask

  task automatic set_all_regs(input logic [7:0] att, input logic [15:0] busy,
                              input logic [14:0] v2, input logic [14:0] leg);
    wait_drained();
    write_reg(CFG_RESP_ATTEMPTS, {8'd0, att});
    write_reg(CFG_BUSY_LIMIT, busy);
    write_reg(CFG_SDV2_RETRIES, {1'b0, v2});
    write_reg(CFG_LEGACY_RETRIES, {1'b0, leg});
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    res_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_send_valid, out_send_byte, out_select_card, out_read_valid,
              out_read_byte, out_took_write_data, out_done_res, out_status, out_card_type};
      if (pending_results.size() == 0) begin
        failed = 1'b1;
        $display("%0t: unexpected result %p", $time, got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          failed = 1'b1;
          $display("%0t: result mismatch expected %p actual %p", $time, want, got);
        end
      end
    end
    out_ready <= !hold_off && ($urandom_range(99) >= rx_idle_pct);
  end

  // idle card bytes are ignored, extremes of the byte fields
  task automatic test_idle_bytes();
    send_item(CMD_BYTE, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    send_item(CMD_BYTE, 32'h0, 8'h00, 8'h00);
  endtask

  // a start request drops the running sequence
  task automatic test_abort();
    send_item(CMD_INIT, 32'h0, 8'h00, 8'h00);
    card_byte(8'hFF);
    send_item(CMD_READ, 32'hFFFF_FFFF, 8'hFF, 8'hFF);
    card_byte(8'hFF);
    card_byte(8'hFF);
    send_item(CMD_WRITE, 32'h8000_0001, 8'h5A, 8'hA5);
    card_byte(8'hFF);
    send_item(CMD_INIT, 32'h0, 8'h00, 8'h00);
  endtask

  // tight limits: single polls, token and busy timeouts, no retries
  task automatic test_tight_limits();
    set_all_regs(8'd1, 16'd1, 15'd1, 15'd1);
    repeat (4) run_request(CMD_INIT, 120);
    run_request(CMD_READ, 40);
    set_all_regs(8'd0, 16'd0, 15'd0, 15'd0);
    repeat (4) run_request(CMD_INIT, 120);
    run_request(CMD_READ, 40);
    run_request(CMD_WRITE, 40);
  endtask

  // mixed requests with random register settings
  task automatic test_random_requests(input int stop_at);
    int pick;
    while (items_sent < stop_at) begin
      if ($urandom_range(15) == 0)
        set_all_regs($urandom_range(3) == 0 ? 8'd255 : 8'($urandom_range(1, 12)),
                     $urandom_range(3) == 0 ? 16'hFFFF : 16'($urandom_range(1, 6)),
                     $urandom_range(3) == 0 ? 15'h7FFF : 15'($urandom_range(1, 5)),
                     $urandom_range(3) == 0 ? 15'h7FFF : 15'($urandom_range(1, 5)));
      pick = $urandom_range(99);
      if (pick < 6) card_byte(8'($urandom_range(255)));
      else if (pick < 80)
        run_request(CMD_INIT, $urandom_range(4) == 0 ? $urandom_range(1, 20) : 300);
      else if (pick < 90) run_request(CMD_READ, $urandom_range(1) ? 20 : 600);
      else run_request(CMD_WRITE, $urandom_range(1) ? 20 : 600);
    end
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_back_pressure();
    fork
      begin
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
      end
      repeat (3) run_request(CMD_INIT, 30);
    join
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_command = CMD_BYTE;
    in_block_address = '0;
    in_card_byte = '0;
    in_write_data = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_RESP_ATTEMPTS;
    cfg_data = '0;
    hold_off = 1'b0;
    failed = 1'b0;
    items_sent = 0;
    tx_idle_pct = 8;
    rx_idle_pct = 87;
    seq_phase = P_IDLE; seq_resume = K_NONE; seq_bytes = '0; seq_attempts = '0;
    seq_retries = '0; seq_cmd = '0; seq_arg = '0; seq_ocr = '0;
    seq_ctype = TYPE_UNKNOWN;
    reg_attempts = 8'd10; reg_busy_limit = 16'hFFFF;
    reg_sdv2_retries = 15'd12000; reg_legacy_retries = 15'd25000;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_idle_bytes();
    test_abort();
    test_tight_limits();
    test_back_pressure();
    test_random_requests(600);
    tx_idle_pct = 87;
    rx_idle_pct = 8;
    test_random_requests(1100);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_requests(1550);
    set_all_regs(8'd255, 16'hFFFF, 15'h7FFF, 15'h7FFF);
    run_request(CMD_INIT, 300);
    wait_drained();
    repeat (10) @(posedge clk);

    if (!failed) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
